/* rtl/core/string_intern_hash_table_defines.svh */
// Assertion macros for the string intern hash table.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef STRING_INTERN_HASH_TABLE_DEFINES_SVH
`define STRING_INTERN_HASH_TABLE_DEFINES_SVH

// Check a property outside of reset
`define STRINTHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every edge, reset included
`define STRINTHT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/strintht_pkg.sv */
// Shared types, codes and helper functions of the string intern hash table.
// No dependencies; used by the controller, the datapath and the top level.
package strintht_pkg;

    // Default sizes
    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int MAX_KEY_BYTES_DEF = 32;
    localparam int POOL_BYTES_DEF    = 4096;

    localparam logic [8:0] TABLE_SIZE_RST = 9'd256;
    localparam int HASH_BITS = 28;

    // Operation codes
    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_LOOKUP = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;
    localparam logic [1:0] FN_NONE   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_KEY_LONG   = 3'd3;
    localparam logic [2:0] ST_POOL_FULL  = 3'd4;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] key_byte;
        logic       last;
        logic [7:0] entry_index;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] result_index;
        logic [5:0] entry_length;
        logic [7:0] data_byte;
        logic       last_result;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic       clr_step;
        logic       key_take;
        logic       key_clear;
        logic       div_load;
        logic       div_step;
        logic       slot_start;
        logic       slot_eidx;
        logic       slot_rd;
        logic       slot_next;
        logic       byte_rd;
        logic       ins_wr;
        logic       ins_commit;
        logic       short_set;
        logic       out_key;
        logic       out_data;
        logic [2:0] out_status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;
        logic eidx_oob;
        logic key_long;
        logic table_full;
        logic div_done;
        logic len_eq;
        logic len_zero;
        logic pool_fits;
        logic pool_short;
        logic probe_last;
        logic byte_eq;
        logic k_eq_len;
        logic k_eq_kc;
    } t_sts;

    // One PJW hash step
    function automatic logic [31:0] pjw_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = {h[27:0], 4'b0000} + {24'd0, b};
        return t ^ ({24'd0, t[31:24]} & 32'h0000_00F0);
    endfunction

    // Preset text of slot zero
    function automatic logic [7:0] nul_byte(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h4E;
            2'd1:    c = 8'h55;
            default: c = 8'h4C;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/strintht_ctrl.sv */
// Controller state machine of the string intern hash table.
// Depends on strintht_pkg; drives the datapath by command, reads its status.
module strintht_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_func,
    input  logic               i_last,
    input  strintht_pkg::t_sts i_sts,
    output strintht_pkg::t_cmd o_cmd,
    output logic               o_busy
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_KEYCHK = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_PR_RD  = 4'd4;
    localparam logic [3:0] S_PR_CHK = 4'd5;
    localparam logic [3:0] S_CMP_RD = 4'd6;
    localparam logic [3:0] S_CMP    = 4'd7;
    localparam logic [3:0] S_INS_RD = 4'd8;
    localparam logic [3:0] S_INS    = 4'd9;
    localparam logic [3:0] S_RD_RD  = 4'd10;
    localparam logic [3:0] S_RD_CHK = 4'd11;
    localparam logic [3:0] S_RD_ISS = 4'd12;
    localparam logic [3:0] S_RD_STR = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_add, n_add;
    strintht_pkg::t_cmd cmd;

    // Step to the next slot, or finish when all slots are probed
    function automatic void next_slot(input logic add, input logic short_seen,
                                      input logic last_slot,
                                      inout strintht_pkg::t_cmd c,
                                      inout logic [3:0] st);
        c.slot_next = 1'b1;
        if (last_slot) begin
            c.out_key   = 1'b1;
            c.key_clear = 1'b1;
            if (!add)
                c.out_status = strintht_pkg::ST_NOT_FOUND;
            else if (short_seen)
                c.out_status = strintht_pkg::ST_POOL_FULL;
            else
                c.out_status = strintht_pkg::ST_TABLE_FULL;
            st = S_IDLE;
        end else begin
            st = S_PR_RD;
        end
    endfunction

    // Sequence one item
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_add   = r_add;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    case (i_func) inside
                        strintht_pkg::FN_ADD, strintht_pkg::FN_LOOKUP: begin
                            cmd.key_take = 1'b1;
                            n_add = (i_func == strintht_pkg::FN_ADD);
                            if (i_last) n_state = S_KEYCHK;
                        end
                        strintht_pkg::FN_READ: begin
                            if (i_sts.eidx_oob) begin
                                cmd.out_key    = 1'b1;
                                cmd.out_status = strintht_pkg::ST_NOT_FOUND;
                            end else begin
                                cmd.slot_eidx = 1'b1;
                                n_state = S_RD_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_KEYCHK: begin
                if (i_sts.key_long) begin
                    cmd.out_key    = 1'b1;
                    cmd.out_status = strintht_pkg::ST_KEY_LONG;
                    cmd.key_clear  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_add && i_sts.table_full) begin
                    cmd.out_key    = 1'b1;
                    cmd.out_status = strintht_pkg::ST_TABLE_FULL;
                    cmd.key_clear  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    cmd.div_load = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    cmd.slot_start = 1'b1;
                    n_state = S_PR_RD;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_PR_RD: begin
                cmd.slot_rd = 1'b1;
                n_state = S_PR_CHK;
            end
            S_PR_CHK: begin
                if (i_sts.len_eq) begin
                    n_state = S_CMP_RD;
                end else if (i_sts.len_zero && !r_add) begin
                    cmd.out_key    = 1'b1;
                    cmd.out_status = strintht_pkg::ST_NOT_FOUND;
                    cmd.key_clear  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_sts.len_zero && i_sts.pool_fits) begin
                    n_state = S_INS_RD;
                end else begin
                    cmd.short_set = i_sts.len_zero;
                    next_slot(r_add, i_sts.pool_short || i_sts.len_zero,
                              i_sts.probe_last, cmd, n_state);
                end
            end
            S_CMP_RD: begin
                cmd.byte_rd = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!i_sts.byte_eq) begin
                    next_slot(r_add, i_sts.pool_short, i_sts.probe_last, cmd, n_state);
                end else if (i_sts.k_eq_len) begin
                    cmd.out_key    = 1'b1;
                    cmd.out_status = strintht_pkg::ST_OK;
                    cmd.key_clear  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    cmd.byte_rd = 1'b1;
                end
            end
            S_INS_RD: begin
                cmd.byte_rd = 1'b1;
                n_state = S_INS;
            end
            S_INS: begin
                cmd.ins_wr = 1'b1;
                if (i_sts.k_eq_kc) begin
                    cmd.ins_commit = 1'b1;
                    cmd.out_key    = 1'b1;
                    cmd.out_status = strintht_pkg::ST_OK;
                    cmd.key_clear  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    cmd.byte_rd = 1'b1;
                end
            end
            S_RD_RD: begin
                cmd.slot_rd = 1'b1;
                n_state = S_RD_CHK;
            end
            S_RD_CHK: begin
                if (i_sts.len_zero) begin
                    cmd.out_key    = 1'b1;
                    cmd.out_status = strintht_pkg::ST_NOT_FOUND;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD_ISS;
                end
            end
            S_RD_ISS: begin
                cmd.byte_rd = 1'b1;
                n_state = S_RD_STR;
            end
            S_RD_STR: begin
                cmd.out_data = 1'b1;
                if (i_sts.k_eq_len) begin
                    n_state = S_IDLE;
                end else begin
                    cmd.byte_rd = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_add   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_add   <= n_add;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

/* rtl/core/strintht_dp.sv */
// Datapath of the string intern hash table: key buffer, hash, remainder unit,
// slot table, byte pool and result register. Depends on strintht_pkg.
module strintht_dp #(
    parameter int TABLE_DEPTH   = strintht_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_KEY_BYTES = strintht_pkg::MAX_KEY_BYTES_DEF,
    parameter int POOL_BYTES    = strintht_pkg::POOL_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  strintht_pkg::t_cmd i_cmd,
    output strintht_pkg::t_sts o_sts,
    input  strintht_pkg::t_in  i_item,
    input  logic               i_cfg_valid,
    input  logic [8:0]         i_cfg_data,
    output logic               o_cfg_ready,
    output logic               o_res_valid,
    output strintht_pkg::t_out o_res
);

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int N_W    = $clog2(TABLE_DEPTH + 1);
    localparam int KC_W   = $clog2(MAX_KEY_BYTES + 2);
    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int LEN_RAW = $clog2(MAX_KEY_BYTES + 1);
    localparam int LEN_W  = (LEN_RAW > 2) ? LEN_RAW : 2;
    localparam int POOL_W = $clog2(POOL_BYTES);
    localparam int FILL_W = $clog2(POOL_BYTES + 1);
    localparam int SE_W   = LEN_W + POOL_W;
    localparam int CLR_N  = (TABLE_DEPTH > 3) ? TABLE_DEPTH : 3;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int HB     = strintht_pkg::HASH_BITS;
    localparam int DIV_W  = $clog2(HB + 1);

    logic [8:0]        r_table_size;
    logic [31:0]       r_hash;
    logic [KC_W-1:0]   r_kc;
    logic [FILL_W-1:0] r_fill;
    logic [N_W-1:0]    r_entries;
    logic [CLR_W-1:0]  r_clr;
    logic [DIV_W-1:0]  r_div_cnt;
    logic [HB-1:0]     r_dvd;
    logic [N_W-1:0]    r_rem;
    logic [SLOT_W-1:0] r_slot;
    logic [N_W-1:0]    r_probe;
    logic              r_short;
    logic [KC_W-1:0]   r_k;
    logic [KC_W-1:0]   r_kw;
    logic [SE_W-1:0]   r_slot_q;
    logic [7:0]        r_pool_q;
    logic [7:0]        r_key_q;
    logic              r_out_valid;
    strintht_pkg::t_out r_out;

    logic [SE_W-1:0] slot_mem [TABLE_DEPTH];
    logic [7:0]      pool_mem [POOL_BYTES];
    logic [7:0]      key_mem  [MAX_KEY_BYTES];

    logic [N_W-1:0]    used_n;
    logic [N_W:0]      rem_sh;
    logic [N_W:0]      rem_nx;
    logic [LEN_W-1:0]  sl_len;
    logic [POOL_W-1:0] sl_off;
    logic [N_W-1:0]    slot_inc;
    logic              clr_slot;
    logic              slot_we;
    logic [SLOT_W-1:0] slot_wa;
    logic [SE_W-1:0]   slot_wd;
    logic              pool_we;
    logic [POOL_W-1:0] pool_wa;
    logic [7:0]        pool_wd;
    logic [POOL_W-1:0] pool_ra;

    // Clamp the slot count in use
    always_comb begin
        if (r_table_size == 9'd0)
            used_n = N_W'(1);
        else if (32'(r_table_size) > TABLE_DEPTH)
            used_n = N_W'(TABLE_DEPTH);
        else
            used_n = N_W'(r_table_size);
    end

    assign sl_len   = r_slot_q[SE_W-1:POOL_W];
    assign sl_off   = r_slot_q[POOL_W-1:0];
    assign slot_inc = N_W'(r_slot) + N_W'(1);

    // One restoring step of the remainder
    assign rem_sh = {r_rem, r_dvd[HB-1]};
    assign rem_nx = (rem_sh >= {1'b0, used_n}) ? rem_sh - {1'b0, used_n} : rem_sh;

    // Status to the controller
    always_comb begin
        o_sts.clr_done   = (32'(r_clr) == CLR_N - 1);
        o_sts.eidx_oob   = (32'(i_item.entry_index) >= 32'(used_n));
        o_sts.key_long   = (32'(r_kc) > MAX_KEY_BYTES);
        o_sts.table_full = (r_entries >= used_n);
        o_sts.div_done   = (r_div_cnt == '0);
        o_sts.len_eq     = (KC_W'(sl_len) == r_kc);
        o_sts.len_zero   = (sl_len == '0);
        o_sts.pool_fits  = ((32'(r_fill) + 32'(r_kc)) <= POOL_BYTES);
        o_sts.pool_short = r_short;
        o_sts.probe_last = ((r_probe + N_W'(1)) == used_n);
        o_sts.byte_eq    = (r_pool_q == r_key_q);
        o_sts.k_eq_len   = (r_k == KC_W'(sl_len));
        o_sts.k_eq_kc    = (r_k == r_kc);
    end

    // Hold the table size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_table_size <= strintht_pkg::TABLE_SIZE_RST;
        else if (i_cfg_valid)
            r_table_size <= i_cfg_data;
    end
    assign o_cfg_ready = 1'b1;

    // Key state, pool fill, entry count and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash    <= '0;
            r_kc      <= '0;
            r_fill    <= FILL_W'(3);
            r_entries <= '0;
            r_clr     <= '0;
        end else begin
            if (i_cmd.clr_step && !o_sts.clr_done)
                r_clr <= r_clr + CLR_W'(1);
            if (i_cmd.key_take) begin
                r_hash <= strintht_pkg::pjw_step(r_hash, i_item.key_byte);
                if (32'(r_kc) <= MAX_KEY_BYTES)
                    r_kc <= r_kc + KC_W'(1);
            end else if (i_cmd.key_clear) begin
                r_hash <= '0;
                r_kc   <= '0;
            end
            if (i_cmd.ins_commit) begin
                r_fill    <= FILL_W'(32'(r_fill) + 32'(r_kc));
                r_entries <= r_entries + N_W'(1);
            end
        end
    end

    // Remainder unit and probe walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_load) begin
            r_div_cnt <= DIV_W'(HB);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - DIV_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd <= r_hash[HB-1:0];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[HB-2:0], 1'b0};
            r_rem <= rem_nx[N_W-1:0];
        end
        if (i_cmd.slot_start) begin
            r_slot  <= r_rem[SLOT_W-1:0];
            r_probe <= '0;
            r_short <= 1'b0;
        end else if (i_cmd.slot_eidx) begin
            r_slot <= SLOT_W'(i_item.entry_index);
        end else if (i_cmd.slot_next) begin
            r_slot  <= (slot_inc == used_n) ? '0 : slot_inc[SLOT_W-1:0];
            r_probe <= r_probe + N_W'(1);
        end
        if (i_cmd.short_set)
            r_short <= 1'b1;
        if (i_cmd.slot_rd) begin
            r_k <= '0;
        end else if (i_cmd.byte_rd) begin
            r_k  <= r_k + KC_W'(1);
            r_kw <= r_k;
        end
    end

    // Slot table: clear pass or commit of a new entry
    assign clr_slot = i_cmd.clr_step && (32'(r_clr) < TABLE_DEPTH);
    always_comb begin
        slot_we = clr_slot || i_cmd.ins_commit;
        if (i_cmd.clr_step) begin
            slot_wa = SLOT_W'(r_clr);
            slot_wd = (r_clr == '0) ? {LEN_W'(3), POOL_W'(0)} : '0;
        end else begin
            slot_wa = r_slot;
            slot_wd = {LEN_W'(r_kc), POOL_W'(r_fill)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        if (i_cmd.slot_rd)
            r_slot_q <= slot_mem[r_slot];
    end

    // Byte pool: preset text or copied key bytes
    always_comb begin
        pool_we = (i_cmd.clr_step && (32'(r_clr) < 3)) || i_cmd.ins_wr;
        if (i_cmd.clr_step) begin
            pool_wa = POOL_W'(r_clr);
            pool_wd = strintht_pkg::nul_byte(2'(r_clr));
        end else begin
            pool_wa = POOL_W'(32'(r_fill) + 32'(r_kw));
            pool_wd = r_key_q;
        end
        pool_ra = POOL_W'(32'(sl_off) + 32'(r_k));
    end

    always_ff @(posedge i_clk) begin
        if (pool_we)
            pool_mem[pool_wa] <= pool_wd;
        if (i_cmd.byte_rd)
            r_pool_q <= pool_mem[pool_ra];
    end

    // Key buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_take && (32'(r_kc) < MAX_KEY_BYTES))
            key_mem[r_kc[KEY_AW-1:0]] <= i_item.key_byte;
        if (i_cmd.byte_rd)
            r_key_q <= key_mem[r_k[KEY_AW-1:0]];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else
            r_out_valid <= i_cmd.out_key || i_cmd.out_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_data) begin
            r_out.status       <= strintht_pkg::ST_OK;
            r_out.result_index <= 8'(r_slot);
            r_out.entry_length <= 6'(sl_len);
            r_out.data_byte    <= r_pool_q;
            r_out.last_result  <= o_sts.k_eq_len;
        end else if (i_cmd.out_key) begin
            r_out.status       <= i_cmd.out_status;
            r_out.result_index <= (i_cmd.out_status == strintht_pkg::ST_OK) ?
                                  8'(r_slot) : 8'd0;
            r_out.entry_length <= '0;
            r_out.data_byte    <= '0;
            r_out.last_result  <= 1'b1;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

/* rtl/core/string_intern_hash_table.sv */
// Top level of the string intern hash table: controller plus datapath.
// Depends on strintht_pkg, strintht_ctrl, strintht_dp and the defines header.
//
//   channel   handshake                  payload
//   command   start / busy               i_cmd (t_in)
//   config    i_cfg_valid / o_cfg_ready  i_cfg_data (table size)
//   result    o_res_valid strobe         o_res (t_out)
//
// A key byte without last is taken while busy stays low. A closing byte runs the
// checks, a bit-serial remainder of 28 steps and a finish, then a slot read and a
// check per probed slot; a slot of equal length adds a compare of up to its length
// in bytes, and an insert adds a copy of the key bytes. A read by index keeps busy
// high through the slot read and check and, for a used slot, the byte stream; an
// index out of range answers at once with busy low. After reset a clearing pass holds busy high.
// Results are strobed for one cycle each; the receiver cannot stall them.
`include "string_intern_hash_table_defines.svh"

module string_intern_hash_table #(
    parameter int TABLE_DEPTH   = strintht_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_KEY_BYTES = strintht_pkg::MAX_KEY_BYTES_DEF,
    parameter int POOL_BYTES    = strintht_pkg::POOL_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  strintht_pkg::t_in  i_cmd,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_data,
    output logic               o_res_valid,
    output strintht_pkg::t_out o_res
);

    strintht_pkg::t_cmd cmd;
    strintht_pkg::t_sts sts;

    // Sequence the work
    strintht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_cmd.func),
        .i_last  (i_cmd.last),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Hold tables, key and result
    strintht_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .POOL_BYTES    (POOL_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (i_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // Clearing pass follows reset
    `STRINTHT_ASSERT_ALWAYS(a_clear_after_reset, !i_rst_n |=> busy, "no clearing pass after reset")
    // Failures never carry a slot
    `STRINTHT_ASSERT(a_fail_index_zero, (o_res_valid && o_res.status != strintht_pkg::ST_OK) |-> (o_res.result_index == 8'd0), "failed transaction with nonzero index")
    // Only read-back carries a length
    `STRINTHT_ASSERT(a_len_only_ok, (o_res_valid && o_res.entry_length != 6'd0) |-> (o_res.status == strintht_pkg::ST_OK), "length on a failed transaction")
    // Read-back stream has no gaps
    `STRINTHT_ASSERT(a_stream_gapless, (o_res_valid && !o_res.last_result) |=> o_res_valid, "gap in read-back stream")

endmodule

/* tb/string_intern_hash_table_tb.sv */
// Self-checking testbench for the string intern hash table.
// Needs strintht_pkg and string_intern_hash_table; its own table model predicts every result.
module string_intern_hash_table_tb;

    localparam int DEPTH      = 256;
    localparam int MAXK       = 32;
    localparam int POOL       = 4096;
    localparam int CYCLE_CAP  = 10000000;

    typedef struct {
        logic [7:0] b[MAXK + 8];
        int         n;
    } key_rec;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    strintht_pkg::t_in  i_cmd = '0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [8:0] i_cfg_data = '0;
    logic       o_res_valid;
    strintht_pkg::t_out o_res;

    // Table model state
    logic [8:0]  tbl_size;
    logic [31:0] pjw_acc;
    logic [7:0]  key_buf[MAXK];
    int          key_len;
    int          slot_len[DEPTH];
    int          slot_off[DEPTH];
    logic [7:0]  pool_mem[POOL];
    int          pool_fill;
    int          entries;

    strintht_pkg::t_out pending_res[$];
    key_rec known_keys[$];
    bit     failed = 1'b0;
    bit     no_gaps = 1'b0;
    int     cycles = 0;
    int     items_sent = 0;

    string_intern_hash_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int slots_used();
        if (tbl_size == 0) return 1;
        if (tbl_size > DEPTH) return DEPTH;
        return int'(tbl_size);
    endfunction

    function automatic strintht_pkg::t_out make_res(logic [2:0] st, int idx, int len, int db,
                                                   bit lr);
        strintht_pkg::t_out r;
        r.status       = st;
        r.result_index = idx[7:0];
        r.entry_length = len[5:0];
        r.data_byte    = db[7:0];
        r.last_result  = lr;
        return r;
    endfunction

    function automatic bit slot_holds_key(int s);
        if (slot_len[s] != key_len) return 1'b0;
        for (int k = 0; k < key_len; k++) begin
            if (slot_off[s] + k >= POOL || pool_mem[slot_off[s] + k] != key_buf[k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Walk the slots from the hash start; store the key on add if an empty slot fits
    function automatic logic [2:0] probe_table(input bit add, output int slot);
        int n;
        int first;
        int s;
        bit short_pool;
        n = slots_used();
        first = int'((pjw_acc & 32'h0FFF_FFFF) % n);
        short_pool = 1'b0;
        slot = 0;
        if (key_len > MAXK) return strintht_pkg::ST_KEY_LONG;
        if (add && entries >= n) return strintht_pkg::ST_TABLE_FULL;
        for (int i = 0; i < n; i++) begin
            s = (first + i) % n;
            if (slot_holds_key(s)) begin
                slot = s;
                return strintht_pkg::ST_OK;
            end
            if (slot_len[s] == 0) begin
                if (!add) return strintht_pkg::ST_NOT_FOUND;
                if (pool_fill + key_len > POOL) begin
                    short_pool = 1'b1;
                end else begin
                    slot_off[s] = pool_fill;
                    for (int k = 0; k < key_len; k++) pool_mem[pool_fill + k] = key_buf[k];
                    pool_fill += key_len;
                    slot_len[s] = key_len;
                    entries++;
                    slot = s;
                    return strintht_pkg::ST_OK;
                end
            end
        end
        if (!add) return strintht_pkg::ST_NOT_FOUND;
        return short_pool ? strintht_pkg::ST_POOL_FULL : strintht_pkg::ST_TABLE_FULL;
    endfunction

    // Compute the results one accepted transaction causes
    function automatic void predict_table(strintht_pkg::t_in it);
        logic [2:0] st;
        int slot;
        int e;
        if (it.func == strintht_pkg::FN_NONE) return;
        if (it.func == strintht_pkg::FN_READ) begin
            e = int'(it.entry_index);
            if (e >= slots_used() || slot_len[e] == 0) begin
                pending_res.push_back(make_res(strintht_pkg::ST_NOT_FOUND, 0, 0, 0, 1'b1));
            end else begin
                for (int k = 0; k < slot_len[e]; k++)
                    pending_res.push_back(make_res(strintht_pkg::ST_OK, e, slot_len[e],
                        (slot_off[e] + k < POOL) ? int'(pool_mem[slot_off[e] + k]) : 0,
                        k + 1 == slot_len[e]));
            end
            return;
        end
        pjw_acc = (pjw_acc << 4) + {24'd0, it.key_byte};
        pjw_acc = pjw_acc ^ ((pjw_acc >> 24) & 32'h0000_00F0);
        if (key_len < MAXK) key_buf[key_len] = it.key_byte;
        if (key_len <= MAXK) key_len++;
        if (!it.last) return;
        st = probe_table(it.func == strintht_pkg::FN_ADD, slot);
        pending_res.push_back(make_res(st, (st == strintht_pkg::ST_OK) ? slot : 0, 0, 0, 1'b1));
        pjw_acc = '0;
        key_len = 0;
    endfunction

    // Check each strobed result against the oldest expectation; bound the run
    always @(posedge i_clk) begin
        strintht_pkg::t_out exp_res;
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_res_valid) begin
            if (pending_res.size() == 0) begin
                $error("unexpected result: status %0d index %0d", o_res.status,
                       o_res.result_index);
                failed = 1'b1;
            end else begin
                exp_res = pending_res.pop_front();
                if (o_res.status !== exp_res.status) begin
                    $error("status: expected %0d, actual %0d", exp_res.status, o_res.status);
                    failed = 1'b1;
                end
                if (o_res.result_index !== exp_res.result_index) begin
                    $error("result_index: expected %0d, actual %0d",
                           exp_res.result_index, o_res.result_index);
                    failed = 1'b1;
                end
                if (o_res.entry_length !== exp_res.entry_length) begin
                    $error("entry_length: expected %0d, actual %0d",
                           exp_res.entry_length, o_res.entry_length);
                    failed = 1'b1;
                end
                if (o_res.data_byte !== exp_res.data_byte) begin
                    $error("data_byte: expected %0h, actual %0h",
                           exp_res.data_byte, o_res.data_byte);
                    failed = 1'b1;
                end
                if (o_res.last_result !== exp_res.last_result) begin
                    $error("last_result: expected %0d, actual %0d",
                           exp_res.last_result, o_res.last_result);
                    failed = 1'b1;
                end
            end
        end
    end

    // Hold one transaction on the command port until the block takes it
    task automatic send_item(input strintht_pkg::t_in it);
        i_cmd <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predict_table(it);
        items_sent++;
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return;
        start <= 1'b0;
        if (r < 90) repeat ($urandom_range(1, 3)) @(posedge i_clk);
        else repeat ($urandom_range(10, 40)) @(posedge i_clk);
    endtask

    // Drop start and wait until every expected result is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [8:0] v);
        drain();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tbl_size = v;
    endtask

    function automatic key_rec rand_key(int n);
        key_rec k;
        k.n = n;
        foreach (k.b[i]) k.b[i] = 8'($urandom);
        return k;
    endfunction

    function automatic key_rec text_key(string s);
        key_rec k;
        k.n = s.len();
        foreach (k.b[i]) k.b[i] = 8'h00;
        for (int i = 0; i < s.len(); i++) k.b[i] = s[i];
        return k;
    endfunction

    // Stream a key; the closing byte carries the operation
    task automatic send_key(input key_rec k, input logic [1:0] fn);
        strintht_pkg::t_in it;
        for (int i = 0; i < k.n; i++) begin
            it.func        = (i == k.n - 1) ? fn : 2'($urandom_range(0, 1));
            it.key_byte    = k.b[i];
            it.last        = (i == k.n - 1);
            it.entry_index = 8'($urandom);
            send_item(it);
            idle_gap();
        end
        if (fn == strintht_pkg::FN_ADD && k.n <= MAXK) known_keys.push_back(k);
    endtask

    task automatic send_read(input int e, input bit lst);
        strintht_pkg::t_in it;
        it.func        = strintht_pkg::FN_READ;
        it.key_byte    = 8'($urandom);
        it.last        = lst;
        it.entry_index = e[7:0];
        send_item(it);
        idle_gap();
    endtask

    function automatic int pick_slot();
        for (int tries = 0; tries < 64; tries++) begin
            int s;
            s = $urandom_range(0, slots_used() - 1);
            if (slot_len[s] != 0) return s;
        end
        return 0;
    endfunction

    task automatic test_directed();
        key_rec k;
        strintht_pkg::t_in it;
        no_gaps = 1'b1;
        send_key(text_key("NUL"), strintht_pkg::FN_LOOKUP);
        send_read(0, 1'b1);
        send_key(text_key("NUL"), strintht_pkg::FN_ADD);
        k = rand_key(1);
        k.b[0] = 8'h00;
        send_key(k, strintht_pkg::FN_ADD);
        send_key(k, strintht_pkg::FN_LOOKUP);
        k.b[0] = 8'hFF;
        send_key(k, strintht_pkg::FN_LOOKUP);
        send_key(k, strintht_pkg::FN_ADD);
        send_key(k, strintht_pkg::FN_ADD);
        no_gaps = 1'b0;
        send_key(rand_key(MAXK), strintht_pkg::FN_ADD);
        send_key(rand_key(MAXK + 1), strintht_pkg::FN_ADD);
        send_key(rand_key(MAXK + 3), strintht_pkg::FN_LOOKUP);
        // Ignored operation and a read inside a partial key
        k = text_key("ab");
        it = '{func: strintht_pkg::FN_ADD, key_byte: k.b[0], last: 1'b0, entry_index: 8'hA5};
        send_item(it);
        it = '{func: strintht_pkg::FN_NONE, key_byte: 8'hFF, last: 1'b1, entry_index: 8'hFF};
        send_item(it);
        send_read(0, 1'b0);
        it = '{func: strintht_pkg::FN_ADD, key_byte: k.b[1], last: 1'b1, entry_index: 8'h5A};
        send_item(it);
        send_read(255, 1'b1);
        send_read(pick_slot(), 1'b1);
        drain();
    endtask

    task automatic test_table_sizes();
        write_size(9'd1);
        send_key(rand_key(2), strintht_pkg::FN_ADD);
        send_key(text_key("NUL"), strintht_pkg::FN_LOOKUP);
        send_read(1, 1'b1);
        write_size(9'd0);
        send_key(rand_key(3), strintht_pkg::FN_LOOKUP);
        send_read(0, 1'b1);
        write_size(9'd511);
        send_key(rand_key(2), strintht_pkg::FN_ADD);
        send_read(pick_slot(), 1'b1);
        write_size(9'd300);
        send_key(rand_key(1), strintht_pkg::FN_ADD);
        write_size(9'd2);
        send_key(rand_key(2), strintht_pkg::FN_ADD);
        write_size(9'd7);
        for (int i = 0; i < 4; i++)
            send_key(rand_key($urandom_range(1, 3)), strintht_pkg::FN_ADD);
        send_read(7, 1'b1);
        send_read(pick_slot(), 1'b1);
        write_size(9'd256);
    endtask

    task automatic test_random();
        int r;
        int n;
        key_rec k;
        strintht_pkg::t_in it;
        while (items_sent < 158) begin
            if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
            r = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAXK + 6)
                                            : $urandom_range(1, 5);
            if (r < 40) begin
                send_key(rand_key(n), strintht_pkg::FN_ADD);
            end else if (r < 60 && known_keys.size() != 0) begin
                k = known_keys[$urandom_range(0, known_keys.size() - 1)];
                send_key(k, 2'($urandom_range(0, 1)));
            end else if (r < 72) begin
                send_key(rand_key(n), strintht_pkg::FN_LOOKUP);
            end else if (r < 88) begin
                send_read(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : pick_slot(),
                          1'b1);
            end else if (r < 94) begin
                it.func        = strintht_pkg::FN_NONE;
                it.key_byte    = 8'($urandom);
                it.last        = 1'($urandom);
                it.entry_index = 8'($urandom);
                send_item(it);
                idle_gap();
            end else begin
                // Hold off until the table has answered everything
                drain();
            end
            if (items_sent > 150 && tbl_size == 256) write_size(9'd13);
        end
        write_size(9'd256);
    endtask

    // Shrink the table just above the entry count and keep adding until it fills
    task automatic test_table_full();
        key_rec k;
        write_size(9'(entries + 2));
        for (int i = 0; i < 4; i++) send_key(rand_key(2), strintht_pkg::FN_ADD);
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        send_key(k, strintht_pkg::FN_ADD);
        send_read(pick_slot(), 1'b1);
        drain();
    endtask

    initial begin
        tbl_size  = strintht_pkg::TABLE_SIZE_RST;
        pjw_acc   = '0;
        key_len   = 0;
        pool_fill = 3;
        entries   = 0;
        foreach (key_buf[i]) key_buf[i] = '0;
        foreach (slot_len[i]) begin
            slot_len[i] = 0;
            slot_off[i] = 0;
        end
        foreach (pool_mem[i]) pool_mem[i] = '0;
        pool_mem[0] = 8'h4E;
        pool_mem[1] = 8'h55;
        pool_mem[2] = 8'h4C;
        slot_len[0] = 3;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_sizes();
        test_random();
        test_table_full();
        drain();
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* string_intern_hash_table.f */
+incdir+rtl/core
rtl/core/strintht_pkg.sv
rtl/core/strintht_ctrl.sv
rtl/core/strintht_dp.sv
rtl/core/string_intern_hash_table.sv
tb/string_intern_hash_table_tb.sv
